// ----- hw/rtl/dhcp_lease_pool_engine_macros.svh -----
// assertion macros shared by the lease pool checkers
// expects clk and arst_n to be visible where a macro is used
`ifndef DHCP_LEASE_POOL_ENGINE_MACROS_SVH
`define DHCP_LEASE_POOL_ENGINE_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define DLPE_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dlpe assertion failed");

// next-cycle implication, disabled while reset is held
`define DLPE_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dlpe assertion failed");

`endif

// ----- hw/rtl/dlpe_pkg.sv -----
// types, codes and constants of the dhcp lease pool engine
// no dependencies
`timescale 1ns / 1ps

package dlpe_pkg;

	localparam int MAC_BYTES = 6;
	localparam int MAC_W     = 8 * MAC_BYTES;

	localparam logic [7:0]  HTYPE_ETH        = 8'd1;
	localparam logic [4:0]  POOL_SIZE_RST    = 5'd16;
	localparam logic [31:0] BASE_ADDR_RST    = 32'hC0A8_0102;
	localparam logic [31:0] LEASE_TICKS_RST  = 32'd360000;

	typedef enum logic [1:0] {
		CMD_DISCOVER = 2'd0,
		CMD_REQUEST  = 2'd1,
		CMD_RELEASE  = 2'd2,
		CMD_OTHER    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		RPL_NONE  = 2'd0,
		RPL_OFFER = 2'd1,
		RPL_ACK   = 2'd2,
		RPL_NAK   = 2'd3
	} reply_t;

	typedef enum logic [2:0] {
		STS_OK      = 3'd0,
		STS_BAD_HW  = 3'd1,
		STS_FULL    = 3'd2,
		STS_NO_ADDR = 3'd3,
		STS_SUBNET  = 3'd4,
		STS_RANGE   = 3'd5,
		STS_TAKEN   = 3'd6,
		STS_UNSUPP  = 3'd7
	} status_t;

	typedef enum logic [1:0] {
		CFG_POOL_SIZE   = 2'd0,
		CFG_BASE_ADDR   = 2'd1,
		CFG_LEASE_TICKS = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		cmd_t        command;
		logic [31:0] now;
		logic [7:0]  hw_type;
		logic [7:0]  hw_len;
		logic [47:0] client_mac;
		logic [31:0] wanted_addr;
		logic        wanted_present;
		logic [31:0] current_addr;
	} in_word_t;

	typedef struct packed {
		reply_t      reply_kind;
		logic [31:0] your_addr;
		logic [3:0]  slot;
		status_t     status;
	} out_word_t;

	typedef struct packed {
		logic [4:0]  pool_size;
		logic [31:0] base_addr;
		logic [31:0] lease_ticks;
	} cfg_t;

	typedef struct packed {
		logic rd_en;
		logic mac_we;
		logic exp_we;
	} store_ctl_t;

	// top len bytes of a mac set, byte zero in the top bits
	function automatic logic [MAC_W-1:0] prefix_mask(input logic [7:0] len);
		logic [MAC_W-1:0] m;
		m = '0;
		for (int b = 0; b < MAC_BYTES; b++) begin
			if (8'(b) < len)
				m[MAC_W-1-8*b -: 8] = 8'hFF;
		end
		return m;
	endfunction

endpackage

// ----- hw/rtl/dhcp_lease_pool_engine.sv -----
// top level of the dhcp lease pool engine: configuration registers and block wiring
// depends on dlpe_pkg, dlpe_store, dlpe_seq
`timescale 1ns / 1ps

// A message word is taken when start is high while busy is low. Every word
// gives exactly one result word, shown on result_word for a single cycle with
// result_valid high; the receiver cannot stall it, so it must take the word in
// that cycle. A message reads the first n slots in turn through the single
// read port of the lease memories, where n is the effective pool size
// (pool_size capped at LEASE_SLOTS), then drains the registered read and
// decides and writes back. The next start is taken in the same cycle the
// result is shown. Lease state is zero after reset with no clearing pass
// (per-entry written flags mask unwritten entries). Configuration is
// written through cfg_we, cfg_idx and cfg_wdata and must only change while
// busy is low.
module dhcp_lease_pool_engine
	import dlpe_pkg::*;
#(
	parameter int LEASE_SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  in_word_t    cmd_word,
	output logic        busy,
	output logic        result_valid,
	output out_word_t   result_word,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [31:0] cfg_wdata
);

	localparam int IDX_W = (LEASE_SLOTS > 1) ? $clog2(LEASE_SLOTS) : 1;

	// configuration registers
	logic [4:0]  pool_size_q;
	logic [31:0] base_addr_q;
	logic [31:0] lease_ticks_q;
	cfg_t        cfg;

	// lease store port
	store_ctl_t       st_ctl;
	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W-1:0] wr_addr;
	logic [MAC_W-1:0] wr_mac;
	logic [31:0]      wr_exp;
	logic [MAC_W-1:0] rd_mac;
	logic [31:0]      rd_exp;

	// unknown register indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_size_q   <= POOL_SIZE_RST;
			base_addr_q   <= BASE_ADDR_RST;
			lease_ticks_q <= LEASE_TICKS_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_POOL_SIZE:   pool_size_q   <= cfg_wdata[4:0];
				CFG_BASE_ADDR:   base_addr_q   <= cfg_wdata;
				CFG_LEASE_TICKS: lease_ticks_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = '{pool_size: pool_size_q, base_addr: base_addr_q,
	               lease_ticks: lease_ticks_q};

	// mac and expiry memories, one entry per lease slot
	dlpe_store #(.DEPTH(LEASE_SLOTS)) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (st_ctl),
		.rd_addr (rd_addr),
		.wr_addr (wr_addr),
		.wr_mac  (wr_mac),
		.wr_exp  (wr_exp),
		.rd_mac  (rd_mac),
		.rd_exp  (rd_exp)
	);

	// sweep and lookup scan, then decision and write-back
	dlpe_seq #(.LEASE_SLOTS(LEASE_SLOTS)) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.start        (start),
		.cmd_word     (cmd_word),
		.busy         (busy),
		.result_valid (result_valid),
		.result_word  (result_word),
		.st_ctl       (st_ctl),
		.rd_addr      (rd_addr),
		.wr_addr      (wr_addr),
		.wr_mac       (wr_mac),
		.wr_exp       (wr_exp),
		.rd_mac       (rd_mac),
		.rd_exp       (rd_exp)
	);

endmodule

// ----- hw/rtl/dlpe_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module dlpe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- hw/rtl/dlpe_store.sv -----
// lease store: mac and expiry rams, per-entry written flags so reset reads zero
// depends on dlpe_pkg, dlpe_ram
`timescale 1ns / 1ps

module dlpe_store
	import dlpe_pkg::*;
#(
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  store_ctl_t       ctl,
	input  logic [AW-1:0]    rd_addr,
	input  logic [AW-1:0]    wr_addr,
	input  logic [MAC_W-1:0] wr_mac,
	input  logic [31:0]      wr_exp,
	output logic [MAC_W-1:0] rd_mac,
	output logic [31:0]      rd_exp
);

	logic [DEPTH-1:0] mac_vld_q;
	logic [DEPTH-1:0] exp_vld_q;
	logic             mac_ok_s1;
	logic             exp_ok_s1;
	logic [MAC_W-1:0] ram_mac;
	logic [31:0]      ram_exp;

	dlpe_ram #(.WIDTH(MAC_W), .DEPTH(DEPTH)) u_mac_ram (
		.clk   (clk),
		.we    (ctl.mac_we),
		.waddr (wr_addr),
		.wdata (wr_mac),
		.re    (ctl.rd_en),
		.raddr (rd_addr),
		.rdata (ram_mac)
	);

	dlpe_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_exp_ram (
		.clk   (clk),
		.we    (ctl.exp_we),
		.waddr (wr_addr),
		.wdata (wr_exp),
		.re    (ctl.rd_en),
		.raddr (rd_addr),
		.rdata (ram_exp)
	);

	// the sequencer never reads and writes one entry in the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_vld_q <= '0;
			exp_vld_q <= '0;
			mac_ok_s1 <= 1'b0;
			exp_ok_s1 <= 1'b0;
		end else begin
			if (ctl.mac_we)
				mac_vld_q[wr_addr] <= 1'b1;
			if (ctl.exp_we)
				exp_vld_q[wr_addr] <= 1'b1;
			if (ctl.rd_en) begin
				mac_ok_s1 <= mac_vld_q[rd_addr];
				exp_ok_s1 <= exp_vld_q[rd_addr];
			end
		end
	end

	assign rd_mac = mac_ok_s1 ? ram_mac : '0;
	assign rd_exp = exp_ok_s1 ? ram_exp : '0;

endmodule

// ----- hw/rtl/dlpe_seq.sv -----
// message sequencer: expiry sweep and lookup scan, decision, write-back
// depends on dlpe_pkg
`timescale 1ns / 1ps

module dlpe_seq
	import dlpe_pkg::*;
#(
	parameter int LEASE_SLOTS = 16,
	localparam int IDX_W = (LEASE_SLOTS > 1) ? $clog2(LEASE_SLOTS) : 1,
	localparam int N_W = $clog2(LEASE_SLOTS + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             start,
	input  in_word_t         cmd_word,
	output logic             busy,
	output logic             result_valid,
	output out_word_t        result_word,
	output store_ctl_t       st_ctl,
	output logic [IDX_W-1:0] rd_addr,
	output logic [IDX_W-1:0] wr_addr,
	output logic [MAC_W-1:0] wr_mac,
	output logic [31:0]      wr_exp,
	input  logic [MAC_W-1:0] rd_mac,
	input  logic [31:0]      rd_exp
);

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_SCAN   = 3'b010,
		S_DECIDE = 3'b100
	} state_t;

	state_t           state_q;
	in_word_t         in_q;
	logic [N_W-1:0]   n_q;
	logic [N_W-1:0]   cnt_q;
	logic [31:0]      req_q;
	logic             have_q;
	logic             subnet_ok_q;
	logic             range_ok_q;
	logic [IDX_W-1:0] offs_q;
	logic             proc_vld_s1;
	logic [IDX_W-1:0] proc_idx_s1;
	logic             match_hit_q;
	logic [IDX_W-1:0] match_idx_q;
	logic             empty_hit_q;
	logic [IDX_W-1:0] empty_idx_q;
	logic [MAC_W-1:0] cap_mac_q;
	logic [31:0]      cap_exp_q;
	logic             res_vld_q;
	out_word_t        res_q;

	logic             accept;
	logic [N_W-1:0]   n_eff;
	logic [31:0]      req_in;
	logic [8:0]       diff;
	logic             rd_go;
	logic             expired;
	logic [31:0]      exp_post;
	logic             hw_ok;
	logic             lk_hit;
	logic [IDX_W-1:0] lk_idx;
	logic [MAC_W-1:0] mask;
	logic [31:0]      exp_sum;
	logic             do_bind;
	logic             do_free;
	out_word_t        dec_res;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);

	// pool size above the slot count acts as the slot count
	assign n_eff = (32'(cfg.pool_size) > LEASE_SLOTS) ? N_W'(LEASE_SLOTS)
	                                                 : N_W'(cfg.pool_size);

	assign req_in = cmd_word.wanted_present ? cmd_word.wanted_addr : cmd_word.current_addr;
	assign diff   = {1'b0, req_in[7:0]} - {1'b0, cfg.base_addr[7:0]};

	assign rd_go   = (state_q == S_SCAN) && (cnt_q < n_q);
	assign rd_addr = cnt_q[IDX_W-1:0];

	assign expired  = (rd_exp != 32'd0) && (rd_exp < in_q.now);
	assign exp_post = expired ? 32'd0 : rd_exp;

	// decision, from the scan results
	assign hw_ok   = (in_q.hw_type == HTYPE_ETH) && (in_q.hw_len <= 8'(MAC_BYTES));
	assign lk_hit  = match_hit_q || empty_hit_q;
	assign lk_idx  = match_hit_q ? match_idx_q : empty_idx_q;
	assign mask    = prefix_mask(in_q.hw_len);
	assign exp_sum = in_q.now + cfg.lease_ticks;

	always_comb begin
		dec_res = '{reply_kind: RPL_NONE, your_addr: 32'd0, slot: 4'd0, status: STS_OK};
		do_bind = 1'b0;
		do_free = 1'b0;
		unique case (in_q.command)
			CMD_DISCOVER: begin
				if (!hw_ok) begin
					dec_res.status = STS_BAD_HW;
				end else if (!lk_hit) begin
					dec_res.status = STS_FULL;
				end else begin
					dec_res.reply_kind = RPL_OFFER;
					dec_res.your_addr  = {cfg.base_addr[31:8],
					                      cfg.base_addr[7:0] + 8'(lk_idx)};
					dec_res.slot       = 4'(lk_idx);
				end
			end
			CMD_REQUEST: begin
				priority if (!hw_ok) begin
					dec_res.status = STS_BAD_HW;
				end else if (!have_q) begin
					dec_res.reply_kind = RPL_NAK;
					dec_res.status     = STS_NO_ADDR;
				end else if (!subnet_ok_q) begin
					dec_res.reply_kind = RPL_NAK;
					dec_res.status     = STS_SUBNET;
				end else if (!range_ok_q) begin
					dec_res.reply_kind = RPL_NAK;
					dec_res.status     = STS_RANGE;
				end else if ((cap_exp_q != 32'd0) &&
				             (((cap_mac_q ^ in_q.client_mac) & mask) != '0)) begin
					dec_res.reply_kind = RPL_NAK;
					dec_res.status     = STS_TAKEN;
					dec_res.slot       = 4'(offs_q);
				end else begin
					dec_res.reply_kind = RPL_ACK;
					dec_res.your_addr  = req_q;
					dec_res.slot       = 4'(offs_q);
					do_bind            = 1'b1;
				end
			end
			CMD_RELEASE: begin
				if (!lk_hit) begin
					dec_res.status = STS_FULL;
				end else begin
					dec_res.slot = 4'(lk_idx);
					do_free      = 1'b1;
				end
			end
			CMD_OTHER: begin
				dec_res.status = STS_UNSUPP;
			end
			default: begin
				dec_res.status = STS_UNSUPP;
			end
		endcase
	end

	// store port: sweep writes during the scan, bind or release at the decision
	always_comb begin
		st_ctl.rd_en  = rd_go;
		st_ctl.mac_we = 1'b0;
		st_ctl.exp_we = 1'b0;
		wr_addr       = proc_idx_s1;
		wr_mac        = (cap_mac_q & ~mask) | (in_q.client_mac & mask);
		wr_exp        = 32'd0;
		if (state_q == S_DECIDE) begin
			if (do_bind) begin
				st_ctl.mac_we = 1'b1;
				st_ctl.exp_we = 1'b1;
				wr_addr       = offs_q;
				wr_exp        = (exp_sum == 32'd0) ? 32'd1 : exp_sum;
			end else if (do_free) begin
				st_ctl.exp_we = 1'b1;
				wr_addr       = lk_idx;
			end
		end else if (proc_vld_s1 && expired) begin
			st_ctl.exp_we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			proc_vld_s1 <= 1'b0;
			res_vld_q   <= 1'b0;
			match_hit_q <= 1'b0;
			empty_hit_q <= 1'b0;
		end else begin
			proc_vld_s1 <= rd_go;
			res_vld_q   <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cnt_q       <= '0;
						match_hit_q <= 1'b0;
						empty_hit_q <= 1'b0;
						state_q     <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (rd_go)
						cnt_q <= cnt_q + 1'b1;
					if (proc_vld_s1) begin
						if ((exp_post == 32'd0) && !empty_hit_q)
							empty_hit_q <= 1'b1;
						else if (!match_hit_q && (rd_mac == in_q.client_mac))
							match_hit_q <= 1'b1;
					end
					if (cnt_q == n_q)
						state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					res_vld_q <= 1'b1;
					state_q   <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload side, no reset
	always_ff @(posedge clk) begin
		proc_idx_s1 <= rd_addr;
		if (accept) begin
			in_q        <= cmd_word;
			n_q         <= n_eff;
			req_q       <= req_in;
			have_q      <= cmd_word.wanted_present || (cmd_word.current_addr != 32'd0);
			subnet_ok_q <= (req_in[31:8] == cfg.base_addr[31:8]);
			range_ok_q  <= !diff[8] && ({1'b0, diff[7:0]} < 9'(n_eff));
			offs_q      <= IDX_W'(diff[7:0]);
		end
		if ((state_q == S_SCAN) && proc_vld_s1) begin
			if ((exp_post == 32'd0) && !empty_hit_q)
				empty_idx_q <= proc_idx_s1;
			else if (!match_hit_q && (rd_mac == in_q.client_mac))
				match_idx_q <= proc_idx_s1;
			if (proc_idx_s1 == offs_q) begin
				cap_mac_q <= rd_mac;
				cap_exp_q <= exp_post;
			end
		end
		if (state_q == S_DECIDE)
			res_q <= dec_res;
	end

	assign result_valid = res_vld_q;
	assign result_word  = res_q;

endmodule

// ----- hw/rtl/dlpe_chk.sv -----
// port-level checks of the dhcp lease pool engine, bound to the top level
// depends on dlpe_pkg and dhcp_lease_pool_engine_macros.svh
`timescale 1ns / 1ps
`include "dhcp_lease_pool_engine_macros.svh"

module dlpe_chk
	import dlpe_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        result_valid,
	input out_word_t   result_word
);

	// an accepted word always starts work
	`DLPE_ASSERT_NXT(a_accept_busy, start && !busy, busy)
	// a result closes exactly one busy period
	`DLPE_ASSERT_IMP(a_result_ends_busy, result_valid, $fell(busy))
	`DLPE_ASSERT_IMP(a_busy_ends_result, $fell(busy), result_valid)
	// offers and acks are always successes
	`DLPE_ASSERT_IMP(a_grant_ok,
		result_valid && (result_word.reply_kind == RPL_OFFER ||
		result_word.reply_kind == RPL_ACK), result_word.status == STS_OK)

endmodule

bind dhcp_lease_pool_engine dlpe_chk u_chk (.*);
